### sv/sh2dec_pkg.sv
// ----------------------------------------------------------------------------
// sh2dec_pkg: shared constants and decode tables for the instruction decoder
// Opcode groups, class numbers and the per-group class lookup functions.
// ----------------------------------------------------------------------------
package sh2dec_pkg;

	// widths of the item fields
	localparam int unsigned OPCODE_W = 16;
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned CLASS_W  = 8;
	localparam int unsigned REG_W    = 4;
	localparam int unsigned IMM_W    = 10;

	typedef logic [CLASS_W-1:0] class_t;
	typedef logic [3:0]         nibble_t;

	// opcode groups, bits 15..12
	localparam nibble_t GRP_0 = 4'h0;
	localparam nibble_t GRP_1 = 4'h1;
	localparam nibble_t GRP_2 = 4'h2;
	localparam nibble_t GRP_3 = 4'h3;
	localparam nibble_t GRP_4 = 4'h4;
	localparam nibble_t GRP_5 = 4'h5;
	localparam nibble_t GRP_6 = 4'h6;
	localparam nibble_t GRP_7 = 4'h7;
	localparam nibble_t GRP_8 = 4'h8;
	localparam nibble_t GRP_9 = 4'h9;
	localparam nibble_t GRP_A = 4'hA;
	localparam nibble_t GRP_B = 4'hB;
	localparam nibble_t GRP_C = 4'hC;
	localparam nibble_t GRP_D = 4'hD;
	localparam nibble_t GRP_E = 4'hE;

	// group 0x8 sub-codes in bits 11..8 that carry an immediate
	localparam nibble_t SUB8_MOVB_ST = 4'h0;
	localparam nibble_t SUB8_MOVW_ST = 4'h1;
	localparam nibble_t SUB8_MOVB_LD = 4'h4;
	localparam nibble_t SUB8_MOVW_LD = 4'h5;
	localparam nibble_t SUB8_CMPEQ   = 4'h8;

	// group 0xC sub-codes in bits 11..8 with scaled displacement
	localparam nibble_t SUBC_WORD_A = 4'h1;
	localparam nibble_t SUBC_WORD_B = 4'h5;
	localparam nibble_t SUBC_LONG_A = 4'h2;
	localparam nibble_t SUBC_LONG_B = 4'h6;
	localparam nibble_t SUBC_MOVA   = 4'h7;

	// class numbers, dense and in group order
	localparam class_t CLS_NONE    = 8'd0;
	localparam class_t CLS_MOVL_SD = 8'd26;
	localparam class_t CLS_MACW    = 8'd94;
	localparam class_t CLS_MOVL_LD = 8'd95;
	localparam class_t CLS_G6_BASE = 8'd96;
	localparam class_t CLS_ADDI    = 8'd112;
	localparam class_t CLS_MOVW_PC = 8'd122;
	localparam class_t CLS_BRA     = 8'd123;
	localparam class_t CLS_BSR     = 8'd124;
	localparam class_t CLS_GC_BASE = 8'd125;
	localparam class_t CLS_MOVL_PC = 8'd141;
	localparam class_t CLS_MOVI    = 8'd142;

	// group 0x0: fixed codes on bits 5..0, then indexed forms on bits 3..0
	function automatic class_t grp0_class(input logic [5:0] low6);
		class_t cls;
		cls = CLS_NONE;
		case (low6)
			6'h08: cls = 8'd1;
			6'h09: cls = 8'd2;
			6'h0B: cls = 8'd3;
			6'h18: cls = 8'd4;
			6'h19: cls = 8'd5;
			6'h1B: cls = 8'd6;
			6'h28: cls = 8'd7;
			6'h2B: cls = 8'd8;
			6'h02: cls = 8'd9;
			6'h03: cls = 8'd10;
			6'h0A: cls = 8'd11;
			6'h12: cls = 8'd12;
			6'h1A: cls = 8'd13;
			6'h22: cls = 8'd14;
			6'h23: cls = 8'd15;
			6'h29: cls = 8'd16;
			6'h2A: cls = 8'd17;
			default: begin
				case (low6[3:0])
					4'h4: cls = 8'd18;
					4'h5: cls = 8'd19;
					4'h6: cls = 8'd20;
					4'h7: cls = 8'd21;
					4'hC: cls = 8'd22;
					4'hD: cls = 8'd23;
					4'hE: cls = 8'd24;
					4'hF: cls = 8'd25;
					default: cls = CLS_NONE;
				endcase
			end
		endcase
		return cls;
	endfunction

	// group 0x2 on bits 3..0
	function automatic class_t grp2_class(input nibble_t n4);
		class_t cls;
		cls = CLS_NONE;
		case (n4)
			4'h0: cls = 8'd27;
			4'h1: cls = 8'd28;
			4'h2: cls = 8'd29;
			4'h4: cls = 8'd30;
			4'h5: cls = 8'd31;
			4'h6: cls = 8'd32;
			4'h7: cls = 8'd33;
			4'h8: cls = 8'd34;
			4'h9: cls = 8'd35;
			4'hA: cls = 8'd36;
			4'hB: cls = 8'd37;
			4'hC: cls = 8'd38;
			4'hD: cls = 8'd39;
			4'hE: cls = 8'd40;
			4'hF: cls = 8'd41;
			default: cls = CLS_NONE;
		endcase
		return cls;
	endfunction

	// group 0x3 on bits 3..0
	function automatic class_t grp3_class(input nibble_t n4);
		class_t cls;
		cls = CLS_NONE;
		case (n4)
			4'h0: cls = 8'd42;
			4'h2: cls = 8'd43;
			4'h3: cls = 8'd44;
			4'h4: cls = 8'd45;
			4'h5: cls = 8'd46;
			4'h6: cls = 8'd47;
			4'h7: cls = 8'd48;
			4'h8: cls = 8'd49;
			4'hA: cls = 8'd50;
			4'hB: cls = 8'd51;
			4'hC: cls = 8'd52;
			4'hD: cls = 8'd53;
			4'hE: cls = 8'd54;
			4'hF: cls = 8'd55;
			default: cls = CLS_NONE;
		endcase
		return cls;
	endfunction

	// group 0x4 on bits 5..0, with MAC.W taking any remaining code ending in 0xF
	function automatic class_t grp4_class(input logic [5:0] low6);
		class_t cls;
		cls = CLS_NONE;
		case (low6)
			6'h00: cls = 8'd56;
			6'h01: cls = 8'd57;
			6'h02: cls = 8'd58;
			6'h03: cls = 8'd59;
			6'h04: cls = 8'd60;
			6'h05: cls = 8'd61;
			6'h06: cls = 8'd62;
			6'h07: cls = 8'd63;
			6'h08: cls = 8'd64;
			6'h09: cls = 8'd65;
			6'h0A: cls = 8'd66;
			6'h0B: cls = 8'd67;
			6'h0E: cls = 8'd68;
			6'h10: cls = 8'd69;
			6'h11: cls = 8'd70;
			6'h12: cls = 8'd71;
			6'h13: cls = 8'd72;
			6'h15: cls = 8'd73;
			6'h16: cls = 8'd74;
			6'h17: cls = 8'd75;
			6'h18: cls = 8'd76;
			6'h19: cls = 8'd77;
			6'h1A: cls = 8'd78;
			6'h1B: cls = 8'd79;
			6'h1E: cls = 8'd80;
			6'h20: cls = 8'd81;
			6'h21: cls = 8'd82;
			6'h22: cls = 8'd83;
			6'h23: cls = 8'd84;
			6'h24: cls = 8'd85;
			6'h25: cls = 8'd86;
			6'h26: cls = 8'd87;
			6'h27: cls = 8'd88;
			6'h28: cls = 8'd89;
			6'h29: cls = 8'd90;
			6'h2A: cls = 8'd91;
			6'h2B: cls = 8'd92;
			6'h2E: cls = 8'd93;
			default: cls = (low6[3:0] == 4'hF) ? CLS_MACW : CLS_NONE;
		endcase
		return cls;
	endfunction

	// group 0x8 on bits 11..8
	function automatic class_t grp8_class(input nibble_t rn);
		class_t cls;
		cls = CLS_NONE;
		case (rn)
			4'h0: cls = 8'd113;
			4'h1: cls = 8'd114;
			4'h4: cls = 8'd115;
			4'h5: cls = 8'd116;
			4'h8: cls = 8'd117;
			4'h9: cls = 8'd118;
			4'hB: cls = 8'd120;
			4'hD: cls = 8'd119;
			4'hF: cls = 8'd121;
			default: cls = CLS_NONE;
		endcase
		return cls;
	endfunction

endpackage

### sv/sh2_instruction_decoder.sv
// ----------------------------------------------------------------------------
// sh2_instruction_decoder: decode of one 16-bit instruction word per transfer
// Two register stages around a single pass of decode and target arithmetic.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries opcode and instr_address. Output
//   channel out_valid/out_ready carries known, instr_class, reg_n, reg_m,
//   immediate, target and at_pc, one result per input transfer, in order.
//   cfg_wr_en/cfg_wr_data write current_pc; write it only while
//   no transfer is in flight.
//   A word passes the input register, then the result register, before its
//   result is presented. Throughput: one transfer per cycle while the
//   receiver keeps out_ready high; the decode and the 32-bit target sum sit
//   between the two registers.
//   Reset clears both stage valid flags and current_pc to zero.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more word, after which in_ready drops until out_ready.
// ----------------------------------------------------------------------------
module sh2_instruction_decoder
	import sh2dec_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [ADDR_W-1:0]   cfg_wr_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [ADDR_W-1:0]   instr_address,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                known,
	output logic [CLASS_W-1:0]  instr_class,
	output logic [REG_W-1:0]    reg_n,
	output logic [REG_W-1:0]    reg_m,
	output logic [IMM_W-1:0]    immediate,
	output logic [ADDR_W-1:0]   target,
	output logic                at_pc
);

	logic [ADDR_W-1:0]   current_pc_q;

	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [ADDR_W-1:0]   addr_s1;

	logic                valid_s2;
	logic                known_s2;
	class_t              class_s2;
	logic [REG_W-1:0]    reg_n_s2;
	logic [REG_W-1:0]    reg_m_s2;
	logic [IMM_W-1:0]    imm_s2;
	logic [ADDR_W-1:0]   target_s2;
	logic                at_pc_s2;

	logic                adv_s1;
	logic                adv_s2;

	nibble_t             grp;
	nibble_t             rn;
	nibble_t             n4;
	logic [7:0]          i8;
	class_t              cls;
	logic [IMM_W-1:0]    imm;
	logic                tgt_en;
	logic [ADDR_W-1:0]   offset;
	logic [ADDR_W-1:0]   tgt;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_pc_q <= '0;
		end else if (cfg_wr_en) begin
			current_pc_q <= cfg_wr_data;
		end
	end

	// stage handshake
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			opcode_s1 <= opcode;
			addr_s1   <= instr_address;
		end
	end

	// field extraction
	assign grp = opcode_s1[15:12];
	assign rn  = opcode_s1[11:8];
	assign n4  = opcode_s1[3:0];
	assign i8  = opcode_s1[7:0];

	// class, scaled immediate and pc-relative offset
	always_comb begin
		cls    = CLS_NONE;
		imm    = '0;
		tgt_en = 1'b0;
		offset = '0;
		case (grp)
			GRP_0: cls = grp0_class(opcode_s1[5:0]);
			GRP_1: begin
				cls = CLS_MOVL_SD;
				imm = {4'd0, n4, 2'd0};
			end
			GRP_2: cls = grp2_class(n4);
			GRP_3: cls = grp3_class(n4);
			GRP_4: cls = grp4_class(opcode_s1[5:0]);
			GRP_5: begin
				cls = CLS_MOVL_LD;
				imm = {4'd0, n4, 2'd0};
			end
			GRP_6: cls = CLS_G6_BASE + {4'd0, n4};
			GRP_7: begin
				cls = CLS_ADDI;
				imm = {2'd0, i8};
			end
			GRP_8: begin
				cls = grp8_class(rn);
				if (rn == SUB8_MOVB_ST || rn == SUB8_MOVB_LD) begin
					imm = {6'd0, n4};
				end else if (rn == SUB8_MOVW_ST || rn == SUB8_MOVW_LD) begin
					imm = {5'd0, n4, 1'b0};
				end else if (rn == SUB8_CMPEQ) begin
					imm = {2'd0, i8};
				end else if (cls != CLS_NONE) begin
					// conditional branch, signed 8-bit word displacement
					tgt_en = 1'b1;
					offset = {{23{i8[7]}}, i8, 1'b0};
				end
			end
			GRP_9: begin
				cls    = CLS_MOVW_PC;
				imm    = {1'b0, i8, 1'b0};
				tgt_en = 1'b1;
				offset = {23'd0, i8, 1'b0};
			end
			GRP_A, GRP_B: begin
				cls    = (grp == GRP_A) ? CLS_BRA : CLS_BSR;
				tgt_en = 1'b1;
				offset = {{19{opcode_s1[11]}}, opcode_s1[11:0], 1'b0};
			end
			GRP_C: begin
				cls = CLS_GC_BASE + {4'd0, rn};
				if (rn == SUBC_WORD_A || rn == SUBC_WORD_B) begin
					imm = {1'b0, i8, 1'b0};
				end else if (rn == SUBC_LONG_A || rn == SUBC_LONG_B || rn == SUBC_MOVA) begin
					imm = {i8, 2'd0};
				end else begin
					imm = {2'd0, i8};
				end
				if (rn == SUBC_MOVA) begin
					tgt_en = 1'b1;
					offset = {22'd0, i8, 2'd0};
				end
			end
			GRP_D: begin
				cls    = CLS_MOVL_PC;
				imm    = {i8, 2'd0};
				tgt_en = 1'b1;
				offset = {22'd0, i8, 2'd0};
			end
			GRP_E: begin
				cls = CLS_MOVI;
				imm = {2'd0, i8};
			end
			default: cls = CLS_NONE;
		endcase
	end

	// target is address plus 4 plus offset, modulo 2^32
	assign tgt = tgt_en ? (addr_s1 + ADDR_W'(4) + offset) : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			known_s2  <= (cls != CLS_NONE);
			class_s2  <= cls;
			reg_n_s2  <= rn;
			reg_m_s2  <= opcode_s1[7:4];
			imm_s2    <= imm;
			target_s2 <= tgt;
			at_pc_s2  <= (addr_s1 == current_pc_q);
		end
	end

	assign out_valid   = valid_s2;
	assign known       = known_s2;
	assign instr_class = class_s2;
	assign reg_n       = reg_n_s2;
	assign reg_m       = reg_m_s2;
	assign immediate   = imm_s2;
	assign target      = target_s2;
	assign at_pc       = at_pc_s2;

	// known flag agrees with the class number
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (known == (instr_class != CLS_NONE)))
		else $error("known flag disagrees with class");

	// undefined codes carry no immediate and no target
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !known) |-> (immediate == '0 && target == '0))
		else $error("undefined code with immediate or target");

	// a held word in the input register is not dropped while the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(opcode_s1) && $stable(addr_s1)))
		else $error("input register lost a word during stall");

	// a result waiting on the receiver is not replaced
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(class_s2) && $stable(target_s2)))
		else $error("result register changed during stall");

endmodule

### tb/sh2_instruction_decoder_test.sv
// ----------------------------------------------------------------------------
// sh2_instruction_decoder_test: self-checking bench for the instruction decoder
// Feeds instruction words with their addresses over valid/ready, predicts each
// decode inside the bench and compares every result transfer field by field.
// A short table of chosen words runs under the reset PC value, then random
// words run under several current PC settings and idle patterns on both sides.
// ----------------------------------------------------------------------------
module sh2_instruction_decoder_test;
	import sh2dec_pkg::*;

	localparam int CLK_HALF          = 4;
	localparam int RESET_CYCLES      = 11;
	localparam int NUM_PROBES        = 26;
	localparam int NUM_PHASES        = 3;
	localparam int RANDOM_PER_PHASE  = 500;
	localparam int SETTLE_CYCLES     = 6;
	localparam int DRAIN_LIMIT       = 20000;
	localparam int LONG_STALL_CYCLES = 48;
	localparam int WATCHDOG_CYCLES   = 500000;

	// one decoded word, in port order
	typedef struct packed {
		logic                known;
		class_t              instr_class;
		logic [REG_W-1:0]    reg_n;
		logic [REG_W-1:0]    reg_m;
		logic [IMM_W-1:0]    immediate;
		logic [ADDR_W-1:0]   target;
		logic                at_pc;
	} decode_t;

	// chosen word; spelled rows carry their decode written out by hand
	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [ADDR_W-1:0]   addr;
		logic                spelled;
		decode_t             want;
	} probe_t;

	localparam decode_t NO_WANT = '0;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [ADDR_W-1:0]   cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ADDR_W-1:0]   instr_address;
	logic                out_valid;
	logic                out_ready;
	logic                known;
	logic [CLASS_W-1:0]  instr_class;
	logic [REG_W-1:0]    reg_n;
	logic [REG_W-1:0]    reg_m;
	logic [IMM_W-1:0]    immediate;
	logic [ADDR_W-1:0]   target;
	logic                at_pc;

	decode_t       expected_decodes [$];
	logic [31:0]   pc_shadow;
	int            send_idle_pct;
	int            recv_idle_pct;
	logic          long_stall_req;
	int            mismatches;
	int            results_checked;
	int            pc_settings;

	// class maps, indexed by the opcode bits each group decodes
	class_t grp0_map [64] = '{
		CLS_NONE, CLS_NONE, 9,        10,       18, 19, 20, 21,
		1,        2,        11,       3,        22, 23, 24, 25,
		CLS_NONE, CLS_NONE, 12,       CLS_NONE, 18, 19, 20, 21,
		4,        5,        13,       6,        22, 23, 24, 25,
		CLS_NONE, CLS_NONE, 14,       15,       18, 19, 20, 21,
		7,        16,       17,       8,        22, 23, 24, 25,
		CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, 18, 19, 20, 21,
		CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, 22, 23, 24, 25
	};
	class_t grp2_map [16] = '{
		27, 28, 29, CLS_NONE, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39, 40, 41
	};
	class_t grp3_map [16] = '{
		42, CLS_NONE, 43, 44, 45, 46, 47, 48, 49, CLS_NONE, 50, 51, 52, 53, 54, 55
	};
	class_t grp4_map [64] = '{
		56, 57, 58, 59, 60, 61, 62, 63,
		64, 65, 66, 67, CLS_NONE, CLS_NONE, 68, CLS_NONE,
		69, 70, 71, 72, CLS_NONE, 73, 74, 75,
		76, 77, 78, 79, CLS_NONE, CLS_NONE, 80, CLS_NONE,
		81, 82, 83, 84, 85, 86, 87, 88,
		89, 90, 91, 92, CLS_NONE, CLS_NONE, 93, CLS_NONE,
		CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE,
		CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE
	};
	class_t grp8_map [16] = '{
		113, 114, CLS_NONE, CLS_NONE, 115, 116, CLS_NONE, CLS_NONE,
		117, 118, CLS_NONE, 120, CLS_NONE, 119, CLS_NONE, 121
	};

	// chosen words, run while current_pc still holds its reset value of zero
	probe_t probe_tab [NUM_PROBES] = '{
		// all-zero word is undefined, address matches the reset PC
		{16'h0000, 32'h0000_0000, 1'b1,
			{1'b0, CLS_NONE, 4'h0, 4'h0, 10'd0, 32'h0000_0000, 1'b1}},
		// group F is undefined throughout
		{16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			{1'b0, CLS_NONE, 4'hF, 4'hF, 10'd0, 32'h0000_0000, 1'b0}},
		{16'h1FFF, 32'h0000_0000, 1'b1,
			{1'b1, CLS_MOVL_SD, 4'hF, 4'hF, 10'd60, 32'h0000_0000, 1'b1}},
		{16'h2A53, 32'h0000_0010, 1'b1,
			{1'b0, CLS_NONE, 4'hA, 4'h5, 10'd0, 32'h0000_0000, 1'b0}},
		{16'h3C19, 32'h0000_0020, 1'b1,
			{1'b0, CLS_NONE, 4'hC, 4'h1, 10'd0, 32'h0000_0000, 1'b0}},
		{16'h403C, 32'h0000_0008, 1'b1,
			{1'b0, CLS_NONE, 4'h0, 4'h3, 10'd0, 32'h0000_0000, 1'b0}},
		{16'h7FFF, 32'h0000_0000, 1'b1,
			{1'b1, CLS_ADDI, 4'hF, 4'hF, 10'd255, 32'h0000_0000, 1'b1}},
		// undefined branch slot gives no target
		{16'h8200, 32'h0000_0000, 1'b1,
			{1'b0, CLS_NONE, 4'h2, 4'h0, 10'd0, 32'h0000_0000, 1'b1}},
		// most negative long branch
		{16'hA800, 32'h0000_0000, 1'b1,
			{1'b1, CLS_BRA, 4'h8, 4'h0, 10'd0, 32'hFFFF_F004, 1'b1}},
		{16'h0009, 32'h0000_1000, 1'b0, NO_WANT},
		{16'h0FFF, 32'h0000_1002, 1'b0, NO_WANT},
		// bits 7..6 are not looked at in groups 0 and 4
		{16'h00C8, 32'h0000_0000, 1'b0, NO_WANT},
		{16'h430F, 32'h0000_0004, 1'b0, NO_WANT},
		{16'h4E3F, 32'h0000_0006, 1'b0, NO_WANT},
		{16'h5FFF, 32'h0000_0000, 1'b0, NO_WANT},
		{16'h6FFF, 32'h0000_0000, 1'b0, NO_WANT},
		// conditional branches: backwards, forward limit, most negative, wrap
		{16'h89FE, 32'hFFFF_FFFC, 1'b0, NO_WANT},
		{16'h8B7F, 32'h0000_0000, 1'b0, NO_WANT},
		{16'h8D80, 32'h0000_0100, 1'b0, NO_WANT},
		{16'h8F00, 32'hFFFF_FFFE, 1'b0, NO_WANT},
		{16'h9FFF, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		{16'hB7FF, 32'hFFFF_F000, 1'b0, NO_WANT},
		// MOVA with the largest displacement wraps to zero
		{16'hC7FF, 32'hFFFF_FC00, 1'b0, NO_WANT},
		{16'hC6FF, 32'h0000_0000, 1'b0, NO_WANT},
		{16'hDFFF, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		{16'hEF80, 32'h0000_0000, 1'b0, NO_WANT}
	};

	sh2_instruction_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.instr_address (instr_address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.known         (known),
		.instr_class   (instr_class),
		.reg_n         (reg_n),
		.reg_m         (reg_m),
		.immediate     (immediate),
		.target        (target),
		.at_pc         (at_pc)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// run limit
	initial begin
		#(WATCHDOG_CYCLES * 2 * CLK_HALF);
		$display("timeout with %0d decodes outstanding", expected_decodes.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// decode of one word as the block should give it
	function automatic decode_t decode_word(input logic [OPCODE_W-1:0] op,
			input logic [ADDR_W-1:0] addr);
		decode_t      d;
		logic [3:0]   n4;
		logic [7:0]   i8;
		logic [31:0]  pc_next;
		logic [31:0]  disp8_x2;
		logic [31:0]  disp12_x2;
		d         = '0;
		n4        = op[3:0];
		i8        = op[7:0];
		pc_next   = addr + 32'd4;
		disp8_x2  = {{23{i8[7]}}, i8, 1'b0};
		disp12_x2 = {{19{op[11]}}, op[11:0], 1'b0};
		d.reg_n   = op[11:8];
		d.reg_m   = op[7:4];
		case (op[15:12])
			GRP_0: d.instr_class = grp0_map[op[5:0]];
			GRP_1: begin
				d.instr_class = CLS_MOVL_SD;
				d.immediate   = {4'b0, n4, 2'b0};
			end
			GRP_2: d.instr_class = grp2_map[n4];
			GRP_3: d.instr_class = grp3_map[n4];
			GRP_4: begin
				d.instr_class = grp4_map[op[5:0]];
				// leftover codes ending in all ones are MAC.W
				if (d.instr_class == CLS_NONE && n4 == 4'hF)
					d.instr_class = CLS_MACW;
			end
			GRP_5: begin
				d.instr_class = CLS_MOVL_LD;
				d.immediate   = {4'b0, n4, 2'b0};
			end
			GRP_6: d.instr_class = CLS_G6_BASE + class_t'(n4);
			GRP_7: begin
				d.instr_class = CLS_ADDI;
				d.immediate   = {2'b0, i8};
			end
			GRP_8: begin
				d.instr_class = grp8_map[op[11:8]];
				case (op[11:8])
					SUB8_MOVB_ST, SUB8_MOVB_LD: d.immediate = {6'b0, n4};
					SUB8_MOVW_ST, SUB8_MOVW_LD: d.immediate = {5'b0, n4, 1'b0};
					SUB8_CMPEQ:                 d.immediate = {2'b0, i8};
					default: begin
						if (d.instr_class != CLS_NONE)
							d.target = pc_next + disp8_x2;
					end
				endcase
			end
			GRP_9: begin
				d.instr_class = CLS_MOVW_PC;
				d.immediate   = {1'b0, i8, 1'b0};
				d.target      = pc_next + {23'b0, i8, 1'b0};
			end
			GRP_A: begin
				d.instr_class = CLS_BRA;
				d.target      = pc_next + disp12_x2;
			end
			GRP_B: begin
				d.instr_class = CLS_BSR;
				d.target      = pc_next + disp12_x2;
			end
			GRP_C: begin
				d.instr_class = CLS_GC_BASE + class_t'(op[11:8]);
				case (op[11:8])
					SUBC_WORD_A, SUBC_WORD_B:            d.immediate = {1'b0, i8, 1'b0};
					SUBC_LONG_A, SUBC_LONG_B, SUBC_MOVA: d.immediate = {i8, 2'b0};
					default:                             d.immediate = {2'b0, i8};
				endcase
				if (op[11:8] == SUBC_MOVA)
					d.target = pc_next + {22'b0, i8, 2'b0};
			end
			GRP_D: begin
				d.instr_class = CLS_MOVL_PC;
				d.immediate   = {i8, 2'b0};
				d.target      = pc_next + {22'b0, i8, 2'b0};
			end
			GRP_E: begin
				d.instr_class = CLS_MOVI;
				d.immediate   = {2'b0, i8};
			end
			default: d.instr_class = CLS_NONE;
		endcase
		d.known = (d.instr_class != CLS_NONE);
		d.at_pc = (addr == pc_shadow);
		return d;
	endfunction

	// addresses biased towards the PC match and both ends of the address space
	function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] pc);
		logic [ADDR_W-1:0] a;
		case ($urandom_range(0, 7))
			0, 1:    a = pc;
			2:       a = pc ^ (32'd1 << $urandom_range(0, 31));
			3:       a = 32'hFFFF_F000 | $urandom_range(0, 4095);
			4:       a = $urandom_range(0, 4095);
			default: a = $urandom;
		endcase
		return a;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// compare one result transfer with the oldest pending decode
	task automatic check_result();
		decode_t w;
		if (expected_decodes.size() == 0) begin
			flag_mismatch("result with nothing pending", {31'b0, known}, 32'h0);
			return;
		end
		w = expected_decodes.pop_front();
		results_checked++;
		if (known !== w.known)
			flag_mismatch("known", 32'(known), 32'(w.known));
		if (instr_class !== w.instr_class)
			flag_mismatch("instr_class", 32'(instr_class), 32'(w.instr_class));
		if (reg_n !== w.reg_n)
			flag_mismatch("reg_n", 32'(reg_n), 32'(w.reg_n));
		if (reg_m !== w.reg_m)
			flag_mismatch("reg_m", 32'(reg_m), 32'(w.reg_m));
		if (immediate !== w.immediate)
			flag_mismatch("immediate", 32'(immediate), 32'(w.immediate));
		if (target !== w.target)
			flag_mismatch("target", target, w.target);
		if (at_pc !== w.at_pc)
			flag_mismatch("at_pc", 32'(at_pc), 32'(w.at_pc));
	endtask

	// receiving side: check transfers, random back-pressure, long hold-off on request
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_result();
			if (stall_left == 0 && long_stall_req) begin
				stall_left     = LONG_STALL_CYCLES;
				long_stall_req = 1'b0;
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// offer one word, holding it until the transfer, then record its decode
	task automatic offer_word(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic spelled, input decode_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		instr_address <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_decodes.push_back(spelled ? want : decode_word(op, addr));
	endtask

	// stop offering and wait for every pending decode, then let the pipe settle
	task automatic drain_results();
		int spin;
		in_valid <= 1'b0;
		for (spin = 0; spin < DRAIN_LIMIT && expected_decodes.size() != 0; spin++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (expected_decodes.size() != 0) begin
			flag_mismatch("decode never delivered", 32'h0, 32'h0);
			void'(expected_decodes.pop_front());
		end
	endtask

	// current_pc write, only while nothing is in flight
	task automatic write_pc(input logic [ADDR_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		pc_shadow   = value;
		pc_settings++;
	endtask

	// stimulus
	initial begin : stimulus
		int                  p;
		int                  k;
		int                  n_random;
		logic [OPCODE_W-1:0] op;
		logic [ADDR_W-1:0]   addr;
		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_wr_data     <= '0;
		in_valid        <= 1'b0;
		opcode          <= '0;
		instr_address   <= '0;
		pc_shadow       = '0;
		send_idle_pct   = 24;
		recv_idle_pct   = 73;
		long_stall_req  = 1'b0;
		mismatches      = 0;
		results_checked = 0;
		pc_settings     = 1;
		n_random        = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// chosen words against the reset value of current_pc
		for (k = 0; k < NUM_PROBES; k++)
			offer_word(probe_tab[k].op, probe_tab[k].addr, probe_tab[k].spelled,
				probe_tab[k].want);
		drain_results();

		// random words: PC at top, random, zero; idle pattern changes per phase
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					write_pc(32'hFFFF_FFFF);
					send_idle_pct = 24;
					recv_idle_pct = 73;
				end
				1: begin
					write_pc($urandom);
					send_idle_pct = 73;
					recv_idle_pct = 24;
				end
				default: begin
					write_pc(32'h0000_0000);
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (k = 0; k < RANDOM_PER_PHASE; k++) begin
				// last phase: fill the block behind a long hold-off, later a full pause
				if (p == NUM_PHASES - 1 && k == 100)
					long_stall_req = 1'b1;
				if (p == NUM_PHASES - 1 && k == 300)
					drain_results();
				op = OPCODE_W'($urandom);
				// extra weight on the groups decoded on six bits
				if ($urandom_range(0, 3) == 0)
					op[15:12] = $urandom_range(0, 1) ? GRP_0 : GRP_4;
				addr = pick_address(pc_shadow);
				offer_word(op, addr, 1'b0, NO_WANT);
				n_random++;
			end
			drain_results();
		end

		$display("covered %0d chosen and %0d random words under %0d current_pc values",
			NUM_PROBES, n_random, pc_settings);
		$display("%0d result transfers compared, %0d field mismatches",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sh2_instruction_decoder.f
sv/sh2dec_pkg.sv
sv/sh2_instruction_decoder.sv
tb/sh2_instruction_decoder_test.sv
